FILE: rtl/brh_pkg.sv
// Shared types, constants and codes of the binned response histogrammer.
package brh_pkg;

	localparam int MOMENTUM_BINS = 6;
	localparam int ETA_BINS      = 10;
	localparam int RESPONSE_BINS = 100;
	localparam int COUNT_WIDTH   = 32;

	localparam int RESP_SLOTS  = RESPONSE_BINS + 2;
	localparam int STORE_DEPTH = MOMENTUM_BINS * ETA_BINS * RESP_SLOTS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	localparam int MOM_W  = 16;
	localparam int ETAV_W = 14;
	localparam int ETAL_W = 13;
	localparam int PB_W   = 3;
	localparam int EB_W   = 4;
	localparam int RB_W   = 7;

	localparam int QBITS     = $clog2(RESPONSE_BINS) + 1;
	localparam int DIV_W     = MOM_W + 1;
	localparam int REM_W     = DIV_W + QBITS;
	localparam int BIN_STEPS = ((MOMENTUM_BINS > ETA_BINS) ? MOMENTUM_BINS : ETA_BINS) - 1;
	localparam int ITER_STEPS = (BIN_STEPS > QBITS) ? BIN_STEPS : QBITS;
	localparam int STEP_W    = $clog2(ITER_STEPS + 1);

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [1:0] REG_MOMENTUM_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_MOMENTUM_BIN_WIDTH = 2'd1;
	localparam logic [1:0] REG_ETA_LIMIT          = 2'd2;
	localparam logic [1:0] REG_ETA_BIN_WIDTH      = 2'd3;

	localparam logic OP_FILL = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIVIDE,
		ST_ADDR,
		ST_READ,
		ST_UPDATE
	} brh_state_t;

	typedef struct packed {
		logic [MOM_W-1:0]  momentum_threshold;
		logic [MOM_W-1:0]  momentum_bin_width;
		logic [ETAL_W-1:0] eta_limit;
		logic [ETAL_W-1:0] eta_bin_width;
	} brh_cfg_t;

	typedef struct packed {
		logic                    op;
		logic [MOM_W-1:0]        measured_momentum;
		logic signed [ETAV_W-1:0] eta_value;
		logic [MOM_W-1:0]        true_momentum;
		logic [PB_W-1:0]         read_momentum_bin;
		logic [EB_W-1:0]         read_eta_bin;
		logic [RB_W-1:0]         read_response_bin;
	} brh_item_t;

	typedef struct packed {
		logic                   accepted;
		logic [PB_W-1:0]        momentum_bin;
		logic [EB_W-1:0]        eta_bin;
		logic [RB_W-1:0]        response_bin;
		logic [COUNT_WIDTH-1:0] bin_count;
	} brh_result_t;

	typedef struct packed {
		logic              clear;
		logic [ADDR_W-1:0] clr_addr;
		logic              load;
		logic              step;
		logic              qstep;
		logic              addr;
		logic              update;
	} brh_cmd_t;

	typedef struct packed {
		logic read_op;
	} brh_status_t;

endpackage

FILE: rtl/brh_in_if.sv
// Input channel interface carrying fill and read transactions.
interface brh_in_if;
	import brh_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     op;
	logic [MOM_W-1:0]         measured_momentum;
	logic signed [ETAV_W-1:0] eta_value;
	logic [MOM_W-1:0]         true_momentum;
	logic [PB_W-1:0]          read_momentum_bin;
	logic [EB_W-1:0]          read_eta_bin;
	logic [RB_W-1:0]          read_response_bin;

	modport source (
		output valid, op, measured_momentum, eta_value, true_momentum,
			read_momentum_bin, read_eta_bin, read_response_bin,
		input  ready
	);

	modport sink (
		input  valid, op, measured_momentum, eta_value, true_momentum,
			read_momentum_bin, read_eta_bin, read_response_bin,
		output ready
	);

endinterface

FILE: rtl/brh_out_if.sv
// Result channel interface carrying one result transaction per input item.
interface brh_out_if;
	import brh_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   accepted;
	logic [PB_W-1:0]        momentum_bin;
	logic [EB_W-1:0]        eta_bin;
	logic [RB_W-1:0]        response_bin;
	logic [COUNT_WIDTH-1:0] bin_count;

	modport source (
		output valid, accepted, momentum_bin, eta_bin, response_bin, bin_count,
		input  ready
	);

	modport sink (
		input  valid, accepted, momentum_bin, eta_bin, response_bin, bin_count,
		output ready
	);

endinterface

FILE: rtl/brh_datapath.sv
// Datapath: acceptance cuts, bin search, response divider, count store and result register.
module brh_datapath (
	input  logic                 clk,
	input  brh_pkg::brh_cfg_t    cfg,
	input  brh_pkg::brh_item_t   item,
	input  brh_pkg::brh_cmd_t    cmd,
	output brh_pkg::brh_status_t status,
	output brh_pkg::brh_result_t result
);
	import brh_pkg::*;

	logic [COUNT_WIDTH-1:0] store_q [STORE_DEPTH];

	logic                   op_q;
	logic                   pass_q;
	logic                   neg_q;
	logic [MOM_W-1:0]       rem_p_q;
	logic [ETAL_W-1:0]      rem_e_q;
	logic [PB_W-1:0]        cnt_p_q;
	logic [EB_W-1:0]        cnt_e_q;
	logic [REM_W-1:0]       rem_v_q;
	logic [REM_W-1:0]       dsh_q;
	logic [QBITS-1:0]       quo_q;
	logic [PB_W-1:0]        rd_pb_q;
	logic [EB_W-1:0]        rd_eb_q;
	logic [RB_W-1:0]        rd_rb_q;
	logic                   ok_q;
	logic [PB_W-1:0]        pb_q;
	logic [EB_W-1:0]        eb_q;
	logic [RB_W-1:0]        rb_q;
	logic [ADDR_W-1:0]      addr_q;
	logic [COUNT_WIDTH-1:0] rdata_q;
	brh_result_t            result_q;

	logic [ETAV_W-1:0]      eta_raw;
	logic [ETAV_W-1:0]      aeta;
	logic                   cut_ok;
	logic [DIV_W:0]         diff;
	logic [MOM_W-1:0]       wp_eff;
	logic [ETAL_W-1:0]      we_eff;
	logic                   rd_ok;
	logic [PB_W-1:0]        pb_sel;
	logic [EB_W-1:0]        eb_sel;
	logic [RB_W-1:0]        rb_fill;
	logic [RB_W-1:0]        rb_sel;
	logic                   ok_sel;
	logic [COUNT_WIDTH-1:0] count_new;
	logic                   store_we;
	logic [ADDR_W-1:0]      store_waddr;
	logic [COUNT_WIDTH-1:0] store_wdata;

	always_comb begin
		eta_raw = item.eta_value;
		aeta    = eta_raw[ETAV_W-1] ? (ETAV_W'(0) - eta_raw) : eta_raw;
		cut_ok  = (item.measured_momentum > cfg.momentum_threshold)
			&& (aeta < {1'b0, cfg.eta_limit})
			&& (item.true_momentum != '0);
		diff    = {1'b0, item.measured_momentum, 1'b0} - {2'b00, item.true_momentum};
		wp_eff  = (cfg.momentum_bin_width == '0) ? MOM_W'(1) : cfg.momentum_bin_width;
		we_eff  = (cfg.eta_bin_width == '0) ? ETAL_W'(1) : cfg.eta_bin_width;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= item.op;
			pass_q  <= cut_ok;
			neg_q   <= diff[DIV_W];
			rem_p_q <= item.measured_momentum - cfg.momentum_threshold - MOM_W'(1);
			rem_e_q <= (aeta == '0) ? '0 : ETAL_W'(aeta - ETAV_W'(1));
			cnt_p_q <= '0;
			cnt_e_q <= '0;
			rem_v_q <= REM_W'(diff[DIV_W-1:0] * REM_W'(RESPONSE_BINS));
			dsh_q   <= REM_W'({item.true_momentum, 1'b0}) << (QBITS - 1);
			quo_q   <= '0;
			rd_pb_q <= item.read_momentum_bin;
			rd_eb_q <= item.read_eta_bin;
			rd_rb_q <= item.read_response_bin;
		end else if (cmd.step) begin
			if (rem_p_q >= wp_eff && cnt_p_q != PB_W'(MOMENTUM_BINS - 1)) begin
				rem_p_q <= rem_p_q - wp_eff;
				cnt_p_q <= cnt_p_q + PB_W'(1);
			end
			if (rem_e_q >= we_eff && cnt_e_q != EB_W'(ETA_BINS - 1)) begin
				rem_e_q <= rem_e_q - we_eff;
				cnt_e_q <= cnt_e_q + EB_W'(1);
			end
			if (cmd.qstep) begin
				if (rem_v_q >= dsh_q) begin
					rem_v_q <= rem_v_q - dsh_q;
					quo_q   <= {quo_q[QBITS-2:0], 1'b1};
				end else begin
					quo_q   <= {quo_q[QBITS-2:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
			end
		end
	end

	always_comb begin
		rd_ok = (int'(rd_pb_q) < MOMENTUM_BINS) && (int'(rd_eb_q) < ETA_BINS)
			&& (int'(rd_rb_q) < RESP_SLOTS);
		if (neg_q) begin
			rb_fill = '0;
		end else if (int'(quo_q) >= RESPONSE_BINS) begin
			rb_fill = RB_W'(RESPONSE_BINS + 1);
		end else begin
			rb_fill = RB_W'(quo_q) + RB_W'(1);
		end
		if (op_q == OP_READ) begin
			ok_sel = rd_ok;
			pb_sel = rd_pb_q;
			eb_sel = rd_eb_q;
			rb_sel = rd_rb_q;
		end else begin
			ok_sel = pass_q;
			pb_sel = cnt_p_q;
			eb_sel = cnt_e_q;
			rb_sel = rb_fill;
		end
		if (!ok_sel) begin
			pb_sel = '0;
			eb_sel = '0;
			rb_sel = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.addr) begin
			ok_q   <= ok_sel;
			pb_q   <= pb_sel;
			eb_q   <= eb_sel;
			rb_q   <= rb_sel;
			addr_q <= ADDR_W'((int'(pb_sel) * ETA_BINS + int'(eb_sel)) * RESP_SLOTS
				+ int'(rb_sel));
		end
	end

	always_comb begin
		if (op_q == OP_READ || rdata_q == '1) begin
			count_new = rdata_q;
		end else begin
			count_new = rdata_q + COUNT_WIDTH'(1);
		end
		store_we    = cmd.clear || (cmd.update && ok_q && op_q == OP_FILL);
		store_waddr = cmd.clear ? cmd.clr_addr : addr_q;
		store_wdata = cmd.clear ? '0 : count_new;
	end

	always_ff @(posedge clk) begin
		if (store_we) begin
			store_q[store_waddr] <= store_wdata;
		end
		rdata_q <= store_q[addr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			result_q.accepted     <= ok_q;
			result_q.momentum_bin <= pb_q;
			result_q.eta_bin      <= eb_q;
			result_q.response_bin <= rb_q;
			result_q.bin_count    <= ok_q ? count_new : '0;
		end
	end

	assign status.read_op = op_q;
	assign result         = result_q;

endmodule

FILE: rtl/brh_ctrl.sv
// Controller: clearing pass, per-item sequencing and result register handshake.
module brh_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	output logic                 result_valid,
	input  logic                 result_ready,
	input  brh_pkg::brh_status_t status,
	output brh_pkg::brh_cmd_t    cmd
);
	import brh_pkg::*;

	brh_state_t        state_q;
	brh_state_t        state_d;
	logic [ADDR_W-1:0] clr_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              room;

	assign room = !out_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (cmd.step) begin
				step_q <= step_q + STEP_W'(1);
			end else begin
				step_q <= '0;
			end
			if (cmd.update) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		item_ready   = 1'b0;
		cmd          = '0;
		cmd.clr_addr = clr_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (clr_q == ADDR_W'(STORE_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (status.read_op == OP_READ) begin
					state_d = ST_ADDR;
				end else begin
					cmd.step  = 1'b1;
					cmd.qstep = (step_q < STEP_W'(QBITS));
					if (step_q == STEP_W'(ITER_STEPS - 1)) begin
						state_d = ST_ADDR;
					end
				end
			end
			ST_ADDR: begin
				cmd.addr = 1'b1;
				state_d  = ST_READ;
			end
			ST_READ: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (room) begin
					cmd.update = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	assign result_valid = out_valid_q;

`ifndef SYNTHESIS
	a_update_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> (!out_valid_q || result_ready))
		else $error("result register overwritten while a transaction is pending");
	a_accept_blocks_next: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> !item_ready)
		else $error("second item taken while one is still in work");
	a_clear_no_traffic: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> (!item_ready && !out_valid_q))
		else $error("traffic during the clearing pass");
	a_qstep_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.qstep |-> cmd.step)
		else $error("divider step outside the iteration phase");
`endif

endmodule

FILE: rtl/binned_response_histogrammer.sv
// Top level: register port, controller and datapath of the binned response histogrammer.
//
//   Channel   Direction  Handshake              Content
//   item      in         valid/ready            fill or read request
//   result    out        valid/ready            one result per item
//   apb       in/out     psel/penable/pready    four configuration registers
//
// A fill passes from acceptance to the result register through load, the iterations of
// the shared bin and response divider loop, address, store read and update. A read passes
// through load, the divider state without iterating, address, store read and update.
// After reset a clearing pass zeroes the count store, one entry per cycle; no item is
// accepted meanwhile, configuration writes are taken throughout.
// A result waiting in the output register does not stop the next item from being
// accepted; that item stalls only at its update cycle until the result is taken.
module binned_response_histogrammer (
	input  logic                        clk,
	input  logic                        arst_n,
	brh_in_if.sink                      item,
	brh_out_if.source                   result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [brh_pkg::PADDR_W-1:0] paddr,
	input  logic [brh_pkg::PDATA_W-1:0] pwdata,
	output logic [brh_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import brh_pkg::*;

	brh_cfg_t    cfg_q;
	brh_item_t   item_pl;
	brh_result_t result_pl;
	brh_cmd_t    cmd;
	brh_status_t status;
	logic [1:0]  reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.momentum_threshold <= MOM_W'(400);
			cfg_q.momentum_bin_width <= MOM_W'(160);
			cfg_q.eta_limit          <= ETAL_W'(2560);
			cfg_q.eta_bin_width      <= ETAL_W'(256);
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_MOMENTUM_THRESHOLD: cfg_q.momentum_threshold <= pwdata[MOM_W-1:0];
				REG_MOMENTUM_BIN_WIDTH: cfg_q.momentum_bin_width <= pwdata[MOM_W-1:0];
				REG_ETA_LIMIT:          cfg_q.eta_limit          <= pwdata[ETAL_W-1:0];
				REG_ETA_BIN_WIDTH:      cfg_q.eta_bin_width      <= pwdata[ETAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MOMENTUM_THRESHOLD: prdata = PDATA_W'(cfg_q.momentum_threshold);
			REG_MOMENTUM_BIN_WIDTH: prdata = PDATA_W'(cfg_q.momentum_bin_width);
			REG_ETA_LIMIT:          prdata = PDATA_W'(cfg_q.eta_limit);
			REG_ETA_BIN_WIDTH:      prdata = PDATA_W'(cfg_q.eta_bin_width);
			default:                prdata = '0;
		endcase
	end

	always_comb begin
		item_pl.op                = item.op;
		item_pl.measured_momentum = item.measured_momentum;
		item_pl.eta_value         = item.eta_value;
		item_pl.true_momentum     = item.true_momentum;
		item_pl.read_momentum_bin = item.read_momentum_bin;
		item_pl.read_eta_bin      = item.read_eta_bin;
		item_pl.read_response_bin = item.read_response_bin;
	end

	brh_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.status       (status),
		.cmd          (cmd)
	);

	brh_datapath u_datapath (
		.clk    (clk),
		.cfg    (cfg_q),
		.item   (item_pl),
		.cmd    (cmd),
		.status (status),
		.result (result_pl)
	);

	assign result.accepted     = result_pl.accepted;
	assign result.momentum_bin = result_pl.momentum_bin;
	assign result.eta_bin      = result_pl.eta_bin;
	assign result.response_bin = result_pl.response_bin;
	assign result.bin_count    = result_pl.bin_count;

endmodule
